/* design/cat_response_line_parser_core_defines.svh */
// Assertion helpers used by the line parser RTL.
`ifndef CAT_RESPONSE_LINE_PARSER_CORE_DEFINES_SVH
`define CAT_RESPONSE_LINE_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CRLP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CRLP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/crlp_pkg.sv */
package crlp_pkg;

    // Field widths
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned FREQ_W     = 32;
    localparam int unsigned MODE_W     = 4;
    localparam int unsigned TIMEOUT_W  = 16;
    localparam int unsigned IDLE_W     = 17;
    localparam int unsigned POS_W      = 8;
    localparam int unsigned OUT_DATA_W = 40;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // Reset values and limits
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5000;
    localparam logic [FREQ_W-1:0]    FREQ_RESET    = 32'd14200000;
    localparam logic [MODE_W-1:0]    MODE_RESET    = 4'd2;
    localparam logic [IDLE_W-1:0]    IDLE_MAX      = 17'h1FFFF;
    localparam logic [POS_W-1:0]     POS_MAX       = 8'hFF;

    // Line length thresholds
    localparam logic [POS_W-1:0] FA_MIN_LEN = 8'd13;
    localparam logic [POS_W-1:0] MD_MIN_LEN = 8'd3;
    localparam logic [POS_W-1:0] IF_MIN_LEN = 8'd31;

    // Positions of interest in a line
    localparam logic [POS_W-1:0] POS_FIRST     = 8'd0;
    localparam logic [POS_W-1:0] POS_SECOND    = 8'd1;
    localparam logic [POS_W-1:0] POS_FREQ_LO   = 8'd2;
    localparam logic [POS_W-1:0] POS_FREQ_HI   = 8'd12;
    localparam logic [POS_W-1:0] POS_MODE_MD   = 8'd2;
    localparam logic [POS_W-1:0] POS_MODE_IF   = 8'd30;

    // Characters
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_F     = 8'h46;
    localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CH_M     = 8'h4D;
    localparam logic [BYTE_W-1:0] CH_D     = 8'h44;
    localparam logic [BYTE_W-1:0] CH_I     = 8'h49;

    // Input kinds carried in tuser
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Register indexes (paddr[2])
    localparam logic REG_TIMEOUT = 1'b0;

    // Default depth of the front-to-back queue
    localparam int unsigned QUEUE_DEPTH = 2;

    // Operation handed from front to back
    typedef enum logic [1:0] {
        OP_CHAR,
        OP_END,
        OP_TICK
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [BYTE_W-1:0] ch;
        logic             blank;
        logic             digit;
    } t_q_item;

    // Queue handshake between modules
    typedef struct packed {
        logic valid;
        logic ready;
    } t_q_ctl;

endpackage

/* design/crlp_front.sv */
module crlp_front (
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [crlp_pkg::BYTE_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]                   s_axis_tuser,   // [0] req_type
    output crlp_pkg::t_q_item            o_item,
    output logic                         o_push,
    input  logic                         i_q_ready
);
    import crlp_pkg::*;

    logic w_accept;
    logic w_is_tick;
    logic w_is_eol;
    logic w_is_semi;

    // Accept whenever the queue has a free slot
    assign s_axis_tready = i_q_ready;
    assign w_accept      = s_axis_tvalid && i_q_ready;

    // Classify the transfer
    assign w_is_tick = (s_axis_tuser[0] == REQ_TICK);
    assign w_is_semi = (s_axis_tdata == CH_SEMI);
    assign w_is_eol  = (s_axis_tdata == CH_CR) || (s_axis_tdata == CH_LF);

    always_comb begin
        o_item.ch    = s_axis_tdata;
        o_item.blank = (s_axis_tdata == CH_SPACE) || (s_axis_tdata == CH_TAB) ||
                       (s_axis_tdata == CH_VT) || (s_axis_tdata == CH_FF);
        o_item.digit = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
        if (w_is_tick) begin
            o_item.op = OP_TICK;
        end else if (w_is_semi) begin
            o_item.op = OP_END;
        end else begin
            o_item.op = OP_CHAR;
        end
    end

    // Drop CR and LF here so they never occupy the queue
    assign o_push = w_accept && (w_is_tick || !w_is_eol);

endmodule

/* design/crlp_queue.sv */
module crlp_queue #(
    parameter int unsigned DEPTH = crlp_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  crlp_pkg::t_q_item   i_item,
    output logic                o_not_full,
    output crlp_pkg::t_q_ctl    o_ctl_valid,
    input  logic                i_pop_ready,
    output crlp_pkg::t_q_item   o_item
);
    import crlp_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_q_item            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               w_pop;
    logic               w_push;

    assign o_not_full        = (r_count != CNT_W'(DEPTH));
    assign o_ctl_valid.valid = (r_count != '0);
    assign o_ctl_valid.ready = o_not_full;
    assign w_push            = i_push && o_not_full;
    assign w_pop             = o_ctl_valid.valid && i_pop_ready;
    assign o_item            = r_mem[r_rd_ptr];

    // Advance pointers with wrap at the configured depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* design/crlp_back.sv */
`include "cat_response_line_parser_core_defines.svh"

module crlp_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [crlp_pkg::TIMEOUT_W-1:0]   i_timeout,
    input  crlp_pkg::t_q_ctl                 i_q_ctl,
    input  crlp_pkg::t_q_item                i_item,
    output logic                             o_pop_ready,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] frequency_hz, [35:32] radio_mode, [36] freq_changed,
    // [37] mode_changed, [38] link_up, [39] zero
    output logic [crlp_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import crlp_pkg::*;

    // Line state
    logic [POS_W-1:0]   r_pos,   n_pos;
    logic [POS_W-1:0]   r_trim,  n_trim;
    logic [BYTE_W-1:0]  r_c0,    n_c0;
    logic [BYTE_W-1:0]  r_c1,    n_c1;
    logic [FREQ_W-1:0]  r_acc,   n_acc;
    logic               r_stop,  n_stop;
    logic [MODE_W-1:0]  r_md2,   n_md2;
    logic [MODE_W-1:0]  r_md30,  n_md30;
    // Radio state
    logic [FREQ_W-1:0]  r_freq,  n_freq;
    logic [MODE_W-1:0]  r_mode,  n_mode;
    logic               r_conn,  n_conn;
    logic [IDLE_W-1:0]  r_idle,  n_idle;
    // Output register
    logic               r_out_valid, n_out_valid;
    logic [FREQ_W-1:0]  r_out_freq,  n_out_freq;
    logic [MODE_W-1:0]  r_out_mode,  n_out_mode;
    logic               r_out_fch,   n_out_fch;
    logic               r_out_mch,   n_out_mch;
    logic               r_out_link,  n_out_link;

    logic               w_pop;
    logic               w_emit;
    logic               w_fch;
    logic               w_mch;
    logic               w_want_freq;
    logic               w_want_mode;
    logic [MODE_W-1:0]  w_mode_sel;
    logic [MODE_W-1:0]  w_digit_val;
    logic [FREQ_W-1:0]  w_acc_next;
    logic [POS_W-1:0]   w_pos_inc;

    // Take the next item when the output slot is free or being drained
    assign o_pop_ready = !r_out_valid || m_axis_tready;
    assign w_pop       = i_q_ctl.valid && o_pop_ready;

    // Multiply by ten and add the digit
    assign w_digit_val = i_item.digit ? i_item.ch[MODE_W-1:0] : '0;
    assign w_acc_next  = {r_acc[FREQ_W-4:0], 3'b000} + {r_acc[FREQ_W-2:0], 1'b0} +
                         {{(FREQ_W-MODE_W){1'b0}}, i_item.ch[MODE_W-1:0]};
    assign w_pos_inc   = (r_pos == POS_MAX) ? POS_MAX : r_pos + 1'b1;

    // Decode the finished line
    always_comb begin
        w_want_freq = 1'b0;
        w_want_mode = 1'b0;
        w_mode_sel  = '0;
        if (r_c0 == CH_F && r_c1 == CH_A && r_trim >= FA_MIN_LEN) begin
            w_want_freq = 1'b1;
        end else if (r_c0 == CH_M && r_c1 == CH_D && r_trim >= MD_MIN_LEN) begin
            w_want_mode = 1'b1;
            w_mode_sel  = r_md2;
        end else if (r_c0 == CH_I && r_c1 == CH_F && r_trim >= IF_MIN_LEN) begin
            w_want_freq = 1'b1;
            w_want_mode = 1'b1;
            w_mode_sel  = r_md30;
        end
    end

    // Carry out one item
    always_comb begin
        n_pos  = r_pos;
        n_trim = r_trim;
        n_c0   = r_c0;
        n_c1   = r_c1;
        n_acc  = r_acc;
        n_stop = r_stop;
        n_md2  = r_md2;
        n_md30 = r_md30;
        n_freq = r_freq;
        n_mode = r_mode;
        n_conn = r_conn;
        n_idle = r_idle;
        w_emit = 1'b0;
        w_fch  = 1'b0;
        w_mch  = 1'b0;
        if (w_pop) begin
            case (i_item.op)
                OP_TICK: begin
                    n_idle = (r_idle == IDLE_MAX) ? r_idle : r_idle + 1'b1;
                    if (r_conn && n_idle > {1'b0, i_timeout}) begin
                        n_conn = 1'b0;
                        w_emit = 1'b1;
                    end
                end
                OP_END: begin
                    if (r_trim != '0) begin
                        n_conn = 1'b1;
                        n_idle = '0;
                        w_emit = 1'b1;
                        if (w_want_freq && r_acc != '0 && r_acc != r_freq) begin
                            n_freq = r_acc;
                            w_fch  = 1'b1;
                        end
                        if (w_want_mode && w_mode_sel != r_mode) begin
                            n_mode = w_mode_sel;
                            w_mch  = 1'b1;
                        end
                    end
                    // Clear the line
                    n_pos  = '0;
                    n_trim = '0;
                    n_c0   = '0;
                    n_c1   = '0;
                    n_acc  = '0;
                    n_stop = 1'b0;
                    n_md2  = '0;
                    n_md30 = '0;
                end
                OP_CHAR: begin
                    // Skip leading blanks
                    if (!(r_pos == POS_FIRST && i_item.blank)) begin
                        if (r_pos == POS_FIRST) begin
                            n_c0 = i_item.ch;
                        end else if (r_pos == POS_SECOND) begin
                            n_c1 = i_item.ch;
                        end
                        if (r_pos >= POS_FREQ_LO && r_pos <= POS_FREQ_HI && !r_stop) begin
                            if (i_item.digit) begin
                                n_acc = w_acc_next;
                            end else begin
                                n_stop = 1'b1;
                            end
                        end
                        if (r_pos == POS_MODE_MD) begin
                            n_md2 = w_digit_val;
                        end
                        if (r_pos == POS_MODE_IF) begin
                            n_md30 = w_digit_val;
                        end
                        if (!i_item.blank) begin
                            n_trim = w_pos_inc;
                        end
                        n_pos = w_pos_inc;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Load or drain the output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_freq  = r_out_freq;
        n_out_mode  = r_out_mode;
        n_out_fch   = r_out_fch;
        n_out_mch   = r_out_mch;
        n_out_link  = r_out_link;
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out_freq  = n_freq;
            n_out_mode  = n_mode;
            n_out_fch   = w_fch;
            n_out_mch   = w_mch;
            n_out_link  = n_conn;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_trim      <= '0;
            r_c0        <= '0;
            r_c1        <= '0;
            r_acc       <= '0;
            r_stop      <= 1'b0;
            r_md2       <= '0;
            r_md30      <= '0;
            r_freq      <= FREQ_RESET;
            r_mode      <= MODE_RESET;
            r_conn      <= 1'b0;
            r_idle      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_trim      <= n_trim;
            r_c0        <= n_c0;
            r_c1        <= n_c1;
            r_acc       <= n_acc;
            r_stop      <= n_stop;
            r_md2       <= n_md2;
            r_md30      <= n_md30;
            r_freq      <= n_freq;
            r_mode      <= n_mode;
            r_conn      <= n_conn;
            r_idle      <= n_idle;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out_freq <= n_out_freq;
        r_out_mode <= n_out_mode;
        r_out_fch  <= n_out_fch;
        r_out_mch  <= n_out_mch;
        r_out_link <= n_out_link;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_link, r_out_mch, r_out_fch, r_out_mode, r_out_freq};

    `CRLP_ASSERT_IMP(a_trim_within_pos, i_clk, i_rst_n, 1'b1, r_trim <= r_pos, "trimmed length past position")
    `CRLP_ASSERT_IMP(a_freq_nonzero, i_clk, i_rst_n, 1'b1, r_freq != '0, "held frequency is zero")
    `CRLP_ASSERT_IMP(a_drop_no_change, i_clk, i_rst_n, r_out_valid && !r_out_link, !r_out_fch && !r_out_mch, "link loss result reports a change")
    `CRLP_ASSERT_NXT(a_end_clears_line, i_clk, i_rst_n, w_pop && i_item.op == OP_END, r_pos == '0 && r_acc == '0, "line not cleared after terminator")

endmodule

/* design/cat_response_line_parser_core.sv */
// Response line parser for a radio CAT serial link. Each input transfer is a
// received byte (tuser 0) or a one millisecond tick (tuser 1). Bytes gather
// into lines ended by ';'; a non-empty line gives one result with the held
// frequency and mode, change flags and link status, and a tick that makes the
// idle count pass timeout_ticks while connected gives one link-loss result.
// All other transfers give no result. The block takes one transfer per cycle
// as long as results are taken; a byte passes from the classifier into a
// queue of QUEUE_DEPTH entries, then through the parser into the output
// register. timeout_ticks lies at APB byte address 0; the user must write it
// only while idle, as the block itself does not enforce this.
module cat_response_line_parser_core #(
    parameter int unsigned QUEUE_DEPTH = crlp_pkg::QUEUE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [crlp_pkg::BYTE_W-1:0]        s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]                         s_axis_tuser,   // [0] req_type
    // Result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] frequency_hz, [35:32] radio_mode, [36] freq_changed,
    // [37] mode_changed, [38] link_up, [39] zero
    output logic [crlp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // Configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [crlp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [crlp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [crlp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import crlp_pkg::*;

    logic [TIMEOUT_W-1:0]  r_timeout;
    logic                  w_cfg_wr;
    t_q_item               w_front_item;
    t_q_item               w_back_item;
    logic                  w_push;
    logic                  w_not_full;
    logic                  w_pop_ready;
    t_q_ctl                w_q_ctl;

    // Configuration register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (w_cfg_wr && paddr[2] == REG_TIMEOUT) begin
            r_timeout <= pwdata[TIMEOUT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_TIMEOUT) ?
                    {{(APB_DATA_W-TIMEOUT_W){1'b0}}, r_timeout} : '0;

    crlp_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_item        (w_front_item),
        .o_push        (w_push),
        .i_q_ready     (w_not_full)
    );

    crlp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_item      (w_front_item),
        .o_not_full  (w_not_full),
        .o_ctl_valid (w_q_ctl),
        .i_pop_ready (w_pop_ready),
        .o_item      (w_back_item)
    );

    crlp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_timeout     (r_timeout),
        .i_q_ctl       (w_q_ctl),
        .i_item        (w_back_item),
        .o_pop_ready   (w_pop_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
